@@ rtl/core/chime_tone_sequencer_macros.svh @@
// Assertion macros used by the chime tone sequencer core.
`ifndef CHIME_TONE_SEQUENCER_MACROS_SVH
`define CHIME_TONE_SEQUENCER_MACROS_SVH

// Condition holds on every edge outside reset.
`define CTS_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent on the same edge.
`define CTS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent on the next edge.
`define CTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/cts_pkg.sv @@
// Types, tone table and helpers shared by the chime tone sequencer.
package cts_pkg;

   localparam int ROM_STEPS    = 40;
   localparam int ROM_PATTERNS = 3;

   typedef enum logic {
      MODE_TICK    = 1'b0,
      MODE_COMMAND = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic [1:0] req_pattern;
      logic [7:0] req_repeats;
   } req_item_type;

   typedef struct packed {
      logic       busy_res;
      logic       tone_enabled;
      logic       tone_restart;
      logic [7:0] tone_compare;
      logic [8:0] tone_period;
   } rsp_item_type;

   localparam logic [8:0] TONE_ROM [ROM_PATTERNS][ROM_STEPS] = '{
      '{9'd250, 9'd200, 9'd166, 9'd142, 9'd126, 9'd110, 9'd100, 9'd90,  9'd82,  9'd76,
        9'd76,  9'd82,  9'd90,  9'd100, 9'd110, 9'd126, 9'd142, 9'd166, 9'd200, 9'd250,
        9'd250, 9'd200, 9'd166, 9'd142, 9'd126, 9'd110, 9'd100, 9'd90,  9'd82,  9'd76,
        9'd76,  9'd82,  9'd90,  9'd100, 9'd110, 9'd126, 9'd142, 9'd166, 9'd200, 9'd250},
      '{9'd110, 9'd110, 9'd110, 9'd72,  9'd72,  9'd72,  9'd110, 9'd110, 9'd110, 9'd332,
        9'd332, 9'd332, 9'd110, 9'd110, 9'd110, 9'd72,  9'd72,  9'd72,  9'd110, 9'd110,
        9'd110, 9'd110, 9'd110, 9'd72,  9'd72,  9'd72,  9'd110, 9'd110, 9'd110, 9'd332,
        9'd332, 9'd332, 9'd110, 9'd110, 9'd110, 9'd72,  9'd72,  9'd72,  9'd110, 9'd110},
      '{9'd82,  9'd332, 9'd126, 9'd100, 9'd82,  9'd250, 9'd110, 9'd76,  9'd142, 9'd90,
        9'd76,  9'd90,  9'd142, 9'd82,  9'd110, 9'd76,  9'd200, 9'd100, 9'd82,  9'd100,
        9'd82,  9'd332, 9'd126, 9'd100, 9'd82,  9'd250, 9'd110, 9'd76,  9'd142, 9'd90,
        9'd76,  9'd90,  9'd142, 9'd82,  9'd110, 9'd76,  9'd200, 9'd100, 9'd82,  9'd100}
   };

   // Steps beyond the table play period zero.
   function automatic logic [8:0] rom_period(input logic [1:0] pattern,
                                             input logic [5:0] step);
      logic [1:0] pat;
      pat = (pattern > 2'd2) ? 2'd0 : pattern;
      if (step < 6'(ROM_STEPS)) begin
         return TONE_ROM[pat][step];
      end
      return 9'd0;
   endfunction

endpackage

@@ rtl/core/cts_input_stage.sv @@
// Input register of the chime tone sequencer.
module cts_input_stage
   import cts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  req_item_type req_item,
   input  logic         take,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;
   assign valid_in   = load ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ rtl/core/cts_core.sv @@
// Sequencer state and single-pass update for one request.
`include "chime_tone_sequencer_macros.svh"

module cts_core
   import cts_pkg::*;
#(
   parameter int STEPS_PER_PATTERN = 40,
   parameter int PATTERN_COUNT     = 3
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  req_item_type item,
   input  logic         rsp_space,
   output logic         fire,
   output rsp_item_type result
);

   localparam logic [5:0] STEP_LAST = 6'(STEPS_PER_PATTERN);
   localparam logic [1:0] PAT_LIMIT = 2'(PATTERN_COUNT);

   logic [1:0] active_ff, active_in;
   logic [1:0] queued_ff, queued_in;
   logic [7:0] repeats_ff, repeats_in;
   logic [5:0] step_ff, step_in;
   logic [8:0] held_ff, held_in;
   logic       on_ff, on_in;
   logic       busy_ff, busy_in;
   logic       restart;
   logic [1:0] pick;
   logic       running;

   assign fire    = item_valid && rsp_space;
   assign running = (repeats_ff != 8'd0);
   assign pick    = (item.req_pattern >= PAT_LIMIT || item.req_pattern > 2'd2) ?
                    2'd0 : item.req_pattern;

   always_comb begin
      active_in  = active_ff;
      queued_in  = queued_ff;
      repeats_in = repeats_ff;
      step_in    = step_ff;
      held_in    = held_ff;
      on_in      = on_ff;
      busy_in    = busy_ff;
      restart    = 1'b0;
      unique case (item.mode)
         MODE_TICK: begin
            if (running) begin
               if (step_ff >= STEP_LAST) begin
                  // end of pass: count down, stop after the last pass, rewind, switch to queued pattern
                  repeats_in = repeats_ff - 8'd1;
                  if (repeats_ff == 8'd1) begin
                     on_in   = 1'b0;
                     busy_in = 1'b0;
                  end
                  step_in   = 6'd0;
                  active_in = queued_ff;
               end else begin
                  held_in = rom_period(active_ff, step_ff);
                  on_in   = 1'b1;
                  restart = 1'b1;
                  step_in = step_ff + 6'd1;
               end
            end
         end
         MODE_COMMAND: begin
            queued_in = pick;
            if (!running && item.req_repeats != 8'd0) begin
               busy_in    = 1'b1;
               active_in  = pick;
               repeats_in = item.req_repeats;
               on_in      = 1'b1;
            end else if (running && item.req_repeats == 8'd0) begin
               repeats_in = 8'd1;
            end else if (running) begin
               repeats_in = (item.req_repeats == 8'hFF) ? 8'hFF :
                            item.req_repeats + 8'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.tone_period  = held_in;
      result.tone_compare = on_in ? held_in[8:1] : 8'd0;
      result.tone_restart = restart;
      result.tone_enabled = on_in;
      result.busy_res     = busy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 2'd0;
         queued_ff  <= 2'd0;
         repeats_ff <= 8'd1;
         step_ff    <= 6'd0;
         held_ff    <= 9'd0;
         on_ff      <= 1'b0;
         busy_ff    <= 1'b0;
      end else if (fire) begin
         active_ff  <= active_in;
         queued_ff  <= queued_in;
         repeats_ff <= repeats_in;
         step_ff    <= step_in;
         held_ff    <= held_in;
         on_ff      <= on_in;
         busy_ff    <= busy_in;
      end
   end

   `CTS_ASSERT_IMPLY(a_busy_drives_tone, clock, reset, busy_ff, on_ff, "busy without tone")
   `CTS_ASSERT_IMPLY(a_stopped_not_busy, clock, reset, repeats_ff == 8'd0, !busy_ff,
      "busy while stopped")
   `CTS_ASSERT_ALWAYS(a_step_in_range, clock, reset, step_ff <= STEP_LAST, "step overrun")
   `CTS_ASSERT_NEXT(a_restart_advances, clock, reset, fire && restart,
      step_ff != 6'd0 && on_ff, "played step did not advance")

endmodule

@@ rtl/core/cts_output_stage.sv @@
// Result register of the chime tone sequencer.
module cts_output_stage
   import cts_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type result,
   output logic         space,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output rsp_item_type rsp_item
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign space    = !valid_ff || rsp_tready;
   assign valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

endmodule

@@ rtl/core/chime_tone_sequencer.sv @@
// Top level of the chime tone sequencer.
//
//   Channel   Dir  Signals                          Carries
//   req       in   req_tvalid/tready/tdata/tuser    tick or command request
//   rsp       out  rsp_tvalid/tready/tdata          tone state after request
//
// One request per clock is sustained while the result side accepts; a request is
// updated combinationally on its way from the input register into the result register.
// Reset is synchronous, active high: empties both registers and loads the
// sequencer with pattern 0, one pass pending, output off.
// A stalled result holds; the input register keeps taking requests as long
// as the result register is free or being drained.
module chime_tone_sequencer
   import cts_pkg::*;
#(
   parameter int STEPS_PER_PATTERN = 40,
   parameter int PATTERN_COUNT     = 3
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [1:0] req_pattern, [9:2] req_repeats, rest zero
   input  logic [0:0]  req_tuser,  // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // [8:0] tone_period, [16:9] tone_compare,
                                   // [17] tone_restart, [18] tone_enabled,
                                   // [19] busy_res, rest zero
);

   req_item_type req_item;
   req_item_type item;
   rsp_item_type result;
   rsp_item_type rsp_item;
   logic         item_valid;
   logic         fire;
   logic         space;

   assign req_item.mode        = mode_type'(req_tuser[0]);
   assign req_item.req_pattern = req_tdata[1:0];
   assign req_item.req_repeats = req_tdata[9:2];

   cts_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   cts_core #(
      .STEPS_PER_PATTERN (STEPS_PER_PATTERN),
      .PATTERN_COUNT     (PATTERN_COUNT)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .rsp_space  (space),
      .fire       (fire),
      .result     (result)
   );

   cts_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .result     (result),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {4'd0, rsp_item};

endmodule

@@ tb/tb_chime_tone_sequencer.sv @@
// Self-checking testbench for the chime tone sequencer: directed and random requests.
`timescale 1ns / 1ps

module tb_chime_tone_sequencer;
   import cts_pkg::*;

   localparam int STEPS      = 40;
   localparam int PATTERNS   = 3;
   localparam int MELODY_LEN = 40;
   localparam int RANDOM_REQUESTS = 600;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int IDLE_MAX        = 17;
   localparam int HOLD_OFF_CYCLES = 300;

   localparam logic [8:0] MELODY [PATTERNS][MELODY_LEN] = '{
      '{9'd250, 9'd200, 9'd166, 9'd142, 9'd126, 9'd110, 9'd100, 9'd90,  9'd82,  9'd76,
        9'd76,  9'd82,  9'd90,  9'd100, 9'd110, 9'd126, 9'd142, 9'd166, 9'd200, 9'd250,
        9'd250, 9'd200, 9'd166, 9'd142, 9'd126, 9'd110, 9'd100, 9'd90,  9'd82,  9'd76,
        9'd76,  9'd82,  9'd90,  9'd100, 9'd110, 9'd126, 9'd142, 9'd166, 9'd200, 9'd250},
      '{9'd110, 9'd110, 9'd110, 9'd72,  9'd72,  9'd72,  9'd110, 9'd110, 9'd110, 9'd332,
        9'd332, 9'd332, 9'd110, 9'd110, 9'd110, 9'd72,  9'd72,  9'd72,  9'd110, 9'd110,
        9'd110, 9'd110, 9'd110, 9'd72,  9'd72,  9'd72,  9'd110, 9'd110, 9'd110, 9'd332,
        9'd332, 9'd332, 9'd110, 9'd110, 9'd110, 9'd72,  9'd72,  9'd72,  9'd110, 9'd110},
      '{9'd82,  9'd332, 9'd126, 9'd100, 9'd82,  9'd250, 9'd110, 9'd76,  9'd142, 9'd90,
        9'd76,  9'd90,  9'd142, 9'd82,  9'd110, 9'd76,  9'd200, 9'd100, 9'd82,  9'd100,
        9'd82,  9'd332, 9'd126, 9'd100, 9'd82,  9'd250, 9'd110, 9'd76,  9'd142, 9'd90,
        9'd76,  9'd90,  9'd142, 9'd82,  9'd110, 9'd76,  9'd200, 9'd100, 9'd82,  9'd100}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [1:0] req_pattern, [9:2] req_repeats, rest zero
   logic [0:0]  req_tuser;   // [0] mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // [8:0] tone_period, [16:9] tone_compare, [17] tone_restart,
                             // [18] tone_enabled, [19] busy_res, rest zero

   // Sequencer state as predicted
   logic [1:0] cur_pattern;
   logic [1:0] queued_pat;
   logic [7:0] passes_left;
   logic [5:0] step_pos;
   logic [8:0] last_period;
   logic       tone_on;
   logic       playing;

   rsp_item_type tone_expected[$];
   int mismatch_count;
   int cycle_count;
   bit send_idle;
   bit recv_idle;
   int rsp_hold_len;

   chime_tone_sequencer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic reset_sequencer();
      cur_pattern  = 2'd0;
      queued_pat   = 2'd0;
      passes_left  = 8'd1;
      step_pos     = 6'd0;
      last_period  = 9'd0;
      tone_on      = 1'b0;
      playing      = 1'b0;
   endtask

   // Apply one request to the predicted state and return the tone it reports.
   task automatic advance_sequencer(input mode_type mode, input logic [1:0] pattern,
                                    input logic [7:0] repeats, output rsp_item_type tone);
      logic       restart;
      logic [1:0] pick;
      restart = 1'b0;
      if (mode == MODE_TICK) begin
         if (passes_left != 8'd0) begin
            if (step_pos >= 6'(STEPS)) begin
               passes_left = passes_left - 8'd1;
               if (passes_left == 8'd0) begin
                  tone_on = 1'b0;
                  playing = 1'b0;
               end
               step_pos    = 6'd0;
               cur_pattern = queued_pat;
            end else begin
               last_period = (step_pos < 6'(MELODY_LEN)) ? MELODY[cur_pattern][step_pos] : 9'd0;
               tone_on     = 1'b1;
               restart     = 1'b1;
               step_pos    = step_pos + 6'd1;
            end
         end
      end else begin
         pick = (pattern >= 2'(PATTERNS)) ? 2'd0 : pattern;
         queued_pat = pick;
         if (passes_left == 8'd0 && repeats != 8'd0) begin
            playing     = 1'b1;
            cur_pattern = pick;
            passes_left = repeats;
            tone_on     = 1'b1;
         end else if (passes_left != 8'd0 && repeats == 8'd0) begin
            passes_left = 8'd1;
         end else if (passes_left != 8'd0) begin
            passes_left = (repeats == 8'd255) ? 8'd255 : repeats + 8'd1;
         end
      end
      tone.tone_period  = last_period;
      tone.tone_compare = tone_on ? last_period[8:1] : 8'd0;
      tone.tone_restart = restart;
      tone.tone_enabled = tone_on;
      tone.busy_res     = playing;
   endtask

   // Offer one request, wait for acceptance and log the tone it must produce.
   task automatic send_request(input mode_type mode, input logic [1:0] pattern,
                               input logic [7:0] repeats);
      int gap;
      rsp_item_type tone;
      gap = send_idle ? $urandom_range(0, IDLE_MAX) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {6'd0, repeats, pattern};
      do @(posedge clock); while (!req_tready);
      advance_sequencer(mode, pattern, repeats, tone);
      tone_expected.push_back(tone);
   endtask

   // Ticks carry random payload, which the block ignores.
   task automatic send_tick();
      send_request(MODE_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
   endtask

   task automatic send_command(input logic [1:0] pattern, input logic [7:0] repeats);
      send_request(MODE_COMMAND, pattern, repeats);
   endtask

   // Power-on pass of pattern 0, stop request with an out-of-range pattern, wrap.
   task automatic test_power_on_pass();
      send_tick();
      send_tick();
      send_command(2'd3, 8'd0);
      repeat (STEPS - 2) send_tick();
      send_tick();
      send_tick();
   endtask

   // Commands while stopped and while running, repeat count saturation.
   task automatic test_commands();
      send_command(2'd2, 8'd0);
      send_tick();
      send_command(2'd1, 8'd1);
      send_tick();
      send_command(2'd1, 8'd255);
      send_command(2'd2, 8'd254);
      send_command(2'd1, 8'd1);
      send_command(2'd0, 8'd0);
      repeat (STEPS + 1) send_tick();
      send_tick();
   endtask

   // Stall the result side for a long stretch so the block backs up.
   task automatic test_backpressure();
      send_idle = 1'b0;
      send_command(2'd2, 8'd2);
      rsp_hold_len = HOLD_OFF_CYCLES;
      repeat (60) send_tick();
      send_idle = 1'b1;
   endtask

   task automatic test_random_play();
      int useful;
      int roll;
      logic [7:0] repeats;
      useful = 0;
      while (useful < RANDOM_REQUESTS) begin
         if (useful % 64 == 0) begin
            send_idle = $urandom_range(0, 2) != 0;
            recv_idle = $urandom_range(0, 2) != 0;
         end
         if ((passes_left == 8'd0 && $urandom_range(0, 3) != 0) || $urandom_range(0, 24) == 0)
         begin
            roll = $urandom_range(0, 99);
            if (roll < 35) repeats = 8'd0;
            else if (roll < 80) repeats = 8'($urandom_range(1, 3));
            else if (roll < 95) repeats = 8'($urandom_range(0, 255));
            else repeats = 8'd255;
            send_command(2'($urandom_range(0, 3)), repeats);
            useful++;
         end else begin
            if (passes_left != 8'd0) useful++;
            send_tick();
         end
      end
   endtask

   // Result side: random stalls, plus a long hold when asked.
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         if (rsp_hold_len > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold_len) @(posedge clock);
            rsp_hold_len = 0;
         end
         stall = recv_idle ? $urandom_range(0, IDLE_MAX) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[19:0];
         if (tone_expected.size() == 0) begin
            $error("unexpected result: tdata %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = tone_expected.pop_front();
            report_field("tone_period", want.tone_period, got.tone_period);
            report_field("tone_compare", want.tone_compare, got.tone_compare);
            report_field("tone_restart", want.tone_restart, got.tone_restart);
            report_field("tone_enabled", want.tone_enabled, got.tone_enabled);
            report_field("busy_res", want.busy_res, got.busy_res);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      mismatch_count = 0;
      cycle_count    = 0;
      rsp_hold_len   = 0;
      send_idle      = 1'b1;
      recv_idle      = 1'b1;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 16'd0;
      req_tuser  <= MODE_TICK;
      reset_sequencer();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_power_on_pass();
      test_commands();
      test_backpressure();
      test_random_play();

      req_tvalid <= 1'b0;
      while (tone_expected.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/cts_pkg.sv
rtl/core/cts_input_stage.sv
rtl/core/cts_core.sv
rtl/core/cts_output_stage.sv
rtl/core/chime_tone_sequencer.sv
tb/tb_chime_tone_sequencer.sv
